// File: src/dfa_pkg.sv
package dfa_pkg;

  // Operation codes
  localparam logic [2:0] OP_INIT    = 3'd0;
  localparam logic [2:0] OP_ALLOC   = 3'd1;
  localparam logic [2:0] OP_FREE    = 3'd2;
  localparam logic [2:0] OP_MARK    = 3'd3;
  localparam logic [2:0] OP_RELEASE = 3'd4;
  localparam logic [2:0] OP_ADJUST  = 3'd5;
  localparam logic [2:0] OP_RESIZE  = 3'd6;
  localparam logic [2:0] OP_QUERY   = 3'd7;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_NOMARK  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_BADADDR = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_END   = 2'd2;

  localparam int unsigned MARK_DEPTH_DEF        = 16;
  localparam int unsigned MARK_RECORD_BYTES_DEF = 16;

  // Mark records sit on 4-byte boundaries; heap blocks round to 4 bytes on resize
  localparam logic [33:0] WORD_MASK = 34'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] size;
    logic [4:0]  align_log2;
    logic        from_tail;
    logic [1:0]  free_mode;
    logic [31:0] tag;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  status;
    logic [31:0] block_address;
    logic [31:0] value;
  } out_item_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] head;
    logic [31:0] tail;
  } mark_t;

endpackage

// File: src/double_ended_frame_allocator_core.sv
// Channel | Ports                          | Handshake
// --------+--------------------------------+----------------------------------
// input   | start, busy, in_data           | taken when start & !busy
// result  | out_valid, out_data            | one-cycle strobe, no back-pressure
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | write when valid & ready
//
// One shared 34-bit add/subtract unit runs each command under a small sequencer.
// Init, free, mark when full and release with no marks finish from idle; the others
// step through states, and release reads and compares each mark entry it walks.
// busy holds off the next word until the last cycle; the result strobe follows it
// and cannot be stalled. Reset (synchronous, rst_n low) clears pointers, mark count
// and config registers; the mark stack holds no reset value and is never read past the count.
module double_ended_frame_allocator_core #(
  parameter int unsigned MARK_DEPTH        = dfa_pkg::MARK_DEPTH_DEF,
  parameter int unsigned MARK_RECORD_BYTES = dfa_pkg::MARK_RECORD_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  dfa_pkg::in_item_t                in_data,
  output logic                             out_valid,
  output dfa_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);

  localparam int unsigned CNT_W = $clog2(MARK_DEPTH + 1);
  localparam int unsigned IDX_W = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam logic [33:0] RECORD_BYTES = 34'(MARK_RECORD_BYTES);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HALIGN = 4'd1;
  localparam logic [3:0] S_HEND   = 4'd2;
  localparam logic [3:0] S_HCHK   = 4'd3;
  localparam logic [3:0] S_QCHK   = 4'd4;
  localparam logic [3:0] S_TSUB   = 4'd5;
  localparam logic [3:0] S_TCHK   = 4'd6;
  localparam logic [3:0] S_RRD    = 4'd7;
  localparam logic [3:0] S_RCMP   = 4'd8;
  localparam logic [3:0] S_ADJ    = 4'd9;
  localparam logic [3:0] S_RSLO   = 4'd10;
  localparam logic [3:0] S_RSHI   = 4'd11;
  localparam logic [3:0] S_RSMRD  = 4'd12;
  localparam logic [3:0] S_RSMCMP = 4'd13;
  localparam logic [3:0] S_RSRND  = 4'd14;

  logic [3:0]  state_r, state_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [31:0] size_r, size_nxt;
  logic [4:0]  al_r, al_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [33:0] w_r, w_nxt;
  logic [33:0] e_r, e_nxt;
  logic [31:0] head_r, head_nxt;
  logic [31:0] tail_r, tail_nxt;
  logic [31:0] rend_r, rend_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0] heap_base_r, data_start_r, data_end_r;
  dfa_pkg::out_item_t out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  // shared add/subtract unit
  logic [33:0] alu_a, alu_b;
  logic        alu_sub;
  logic [34:0] alu_res;
  logic        alu_lt;

  logic [33:0] align_mask;
  dfa_pkg::mark_t ram_wdata, ram_rdata;
  logic        ram_we;

  assign alu_res = {1'b0, alu_a} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
                   + 35'(alu_sub);
  assign alu_lt  = alu_res[34];

  assign align_mask = (34'd1 << al_r) - 34'd1;

  assign ram_wdata = '{tag: tag_r, head: e_r[31:0], tail: tail_r};

  dfa_ram #(
    .WIDTH ($bits(dfa_pkg::mark_t)),
    .DEPTH (MARK_DEPTH),
    .AW    (IDX_W)
  ) u_mark_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic        fin;
    logic [2:0]  fin_status;
    logic [31:0] fin_blk;
    logic [31:0] fin_val;
    logic [33:0] mask_sel;

    fin        = 1'b0;
    fin_status = dfa_pkg::ST_OK;
    fin_blk    = '0;
    fin_val    = '0;
    mask_sel   = (op_r == dfa_pkg::OP_MARK) ? dfa_pkg::WORD_MASK : align_mask;

    state_nxt     = state_r;
    op_nxt        = op_r;
    size_nxt      = size_r;
    al_nxt        = al_r;
    tag_nxt       = tag_r;
    addr_nxt      = addr_r;
    idx_nxt       = idx_r;
    w_nxt         = w_r;
    e_nxt         = e_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    rend_nxt      = rend_r;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_data.operation;
          size_nxt = (in_data.size == 32'd0) ? 32'd1 : in_data.size;
          al_nxt   = in_data.align_log2;
          tag_nxt  = in_data.tag;
          addr_nxt = in_data.address;
          idx_nxt  = IDX_W'(count_r - CNT_W'(1));
          unique case (in_data.operation)
            dfa_pkg::OP_INIT: begin
              head_nxt  = data_start_r;
              tail_nxt  = data_end_r;
              rend_nxt  = data_end_r;
              count_nxt = '0;
              fin       = 1'b1;
            end
            dfa_pkg::OP_ALLOC: begin
              state_nxt = in_data.from_tail ? S_TSUB : S_HALIGN;
            end
            dfa_pkg::OP_FREE: begin
              if (in_data.free_mode[0]) begin
                head_nxt  = data_start_r;
                count_nxt = '0;
              end
              if (in_data.free_mode[1]) begin
                tail_nxt  = rend_r;
                count_nxt = '0;
              end
              fin = 1'b1;
            end
            dfa_pkg::OP_MARK: begin
              if (count_r >= CNT_W'(MARK_DEPTH)) begin
                fin        = 1'b1;
                fin_status = dfa_pkg::ST_FULL;
              end else begin
                state_nxt = S_HALIGN;
              end
            end
            dfa_pkg::OP_RELEASE: begin
              if (count_r == '0) begin
                fin        = 1'b1;
                fin_status = dfa_pkg::ST_NOMARK;
              end else begin
                state_nxt = S_RRD;
              end
            end
            dfa_pkg::OP_ADJUST: state_nxt = S_ADJ;
            dfa_pkg::OP_RESIZE: state_nxt = S_RSLO;
            dfa_pkg::OP_QUERY:  state_nxt = S_HALIGN;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end

      // round head up to the alignment
      S_HALIGN: begin
        alu_a     = {2'b00, head_r};
        alu_b     = mask_sel;
        w_nxt     = alu_res[33:0] & ~mask_sel;
        state_nxt = (op_r == dfa_pkg::OP_QUERY) ? S_QCHK : S_HEND;
      end

      S_HEND: begin
        alu_a     = w_r;
        alu_b     = (op_r == dfa_pkg::OP_MARK) ? RECORD_BYTES : {2'b00, size_r};
        e_nxt     = alu_res[33:0];
        state_nxt = (op_r == dfa_pkg::OP_RESIZE) ? S_RSRND : S_HCHK;
      end

      // end past tail also covers end past the 32-bit space
      S_HCHK: begin
        alu_a   = {2'b00, tail_r};
        alu_b   = e_r;
        alu_sub = 1'b1;
        fin     = 1'b1;
        if (alu_lt) begin
          fin_status = dfa_pkg::ST_NOSPACE;
        end else begin
          head_nxt = e_r[31:0];
          if (op_r == dfa_pkg::OP_RESIZE) begin
            fin_val = size_r;
          end else begin
            fin_blk = w_r[31:0];
          end
          if (op_r == dfa_pkg::OP_MARK) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end

      S_QCHK: begin
        alu_a   = {2'b00, tail_r};
        alu_b   = w_r;
        alu_sub = 1'b1;
        fin     = 1'b1;
        if (!alu_lt) begin
          fin_val = alu_res[31:0];
        end
      end

      S_TSUB: begin
        alu_a   = {2'b00, tail_r};
        alu_b   = {2'b00, size_r};
        alu_sub = 1'b1;
        if (alu_lt) begin
          fin        = 1'b1;
          fin_status = dfa_pkg::ST_NOSPACE;
        end else begin
          w_nxt     = {2'b00, alu_res[31:0]} & ~align_mask;
          state_nxt = S_TCHK;
        end
      end

      S_TCHK: begin
        alu_a   = w_r;
        alu_b   = {2'b00, head_r};
        alu_sub = 1'b1;
        fin     = 1'b1;
        if (alu_lt) begin
          fin_status = dfa_pkg::ST_NOSPACE;
        end else begin
          tail_nxt = w_r[31:0];
          fin_blk  = w_r[31:0];
        end
      end

      S_RRD: state_nxt = S_RCMP;

      // walk down the mark stack until the tag matches
      S_RCMP: begin
        if (tag_r == 32'd0 || ram_rdata.tag == tag_r) begin
          head_nxt  = ram_rdata.head;
          tail_nxt  = ram_rdata.tail;
          count_nxt = CNT_W'(idx_r);
          fin       = 1'b1;
        end else if (idx_r == '0) begin
          fin        = 1'b1;
          fin_status = dfa_pkg::ST_NOMARK;
        end else begin
          idx_nxt   = idx_r - IDX_W'(1);
          state_nxt = S_RRD;
        end
      end

      S_ADJ: begin
        alu_a   = {2'b00, head_r};
        alu_b   = {2'b00, heap_base_r};
        alu_sub = 1'b1;
        fin     = 1'b1;
        if (tail_r == rend_r) begin
          rend_nxt = head_r;
          tail_nxt = head_r;
          fin_val  = alu_res[31:0];
        end else begin
          fin_status = dfa_pkg::ST_NOSPACE;
        end
      end

      S_RSLO: begin
        alu_a   = {2'b00, addr_r};
        alu_b   = {2'b00, data_start_r};
        alu_sub = 1'b1;
        if (alu_lt) begin
          fin        = 1'b1;
          fin_status = dfa_pkg::ST_BADADDR;
        end else begin
          state_nxt = S_RSHI;
        end
      end

      S_RSHI: begin
        alu_a   = {2'b00, addr_r};
        alu_b   = {2'b00, head_r};
        alu_sub = 1'b1;
        if (!alu_lt) begin
          fin        = 1'b1;
          fin_status = dfa_pkg::ST_BADADDR;
        end else begin
          w_nxt     = {2'b00, addr_r};
          state_nxt = (count_r != '0) ? S_RSMRD : S_HEND;
        end
      end

      S_RSMRD: state_nxt = S_RSMCMP;

      // block must not start below the newest mark
      S_RSMCMP: begin
        alu_a   = {2'b00, addr_r};
        alu_b   = {2'b00, ram_rdata.head};
        alu_sub = 1'b1;
        if (alu_lt) begin
          fin        = 1'b1;
          fin_status = dfa_pkg::ST_BADADDR;
        end else begin
          state_nxt = S_HEND;
        end
      end

      S_RSRND: begin
        alu_a     = e_r;
        alu_b     = dfa_pkg::WORD_MASK;
        e_nxt     = alu_res[33:0] & ~dfa_pkg::WORD_MASK;
        state_nxt = S_HCHK;
      end

      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      state_nxt              = S_IDLE;
      out_valid_nxt          = 1'b1;
      out_nxt.ok             = (fin_status == dfa_pkg::ST_OK);
      out_nxt.status         = fin_status;
      out_nxt.block_address  = fin_blk;
      out_nxt.value          = fin_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      rend_r       <= '0;
      count_r      <= '0;
      heap_base_r  <= '0;
      data_start_r <= '0;
      data_end_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      rend_r      <= rend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          dfa_pkg::CFG_HEAP_BASE:  heap_base_r  <= cfg_data;
          dfa_pkg::CFG_DATA_START: data_start_r <= cfg_data;
          dfa_pkg::CFG_DATA_END:   data_end_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    size_r <= size_nxt;
    al_r   <= al_nxt;
    tag_r  <= tag_nxt;
    addr_r <= addr_nxt;
    idx_r  <= idx_nxt;
    w_r    <= w_nxt;
    e_r    <= e_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/dfa_ram.sv
module dfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
